[src/lfsc_pkg.sv]
`default_nettype none

package lfsc_pkg;

  localparam int DIV_W = 17;
  localparam int DVS_W = 9;
  localparam logic [4:0] DIV_STEPS = 5'd17;

  localparam logic [1:0] MS_HOLD   = 2'd0;
  localparam logic [1:0] MS_ACCEL  = 2'd1;
  localparam logic [1:0] MS_DECEL  = 2'd2;
  localparam logic [1:0] MS_URGENT = 2'd3;

  localparam logic [2:0] REG_LIGHT_LOW  = 3'd0;
  localparam logic [2:0] REG_LIGHT_HIGH = 3'd1;
  localparam logic [2:0] REG_LIGHT_MIN  = 3'd2;
  localparam logic [2:0] REG_LIGHT_MAX  = 3'd3;
  localparam logic [2:0] REG_DIST_URG   = 3'd4;
  localparam logic [2:0] REG_DIST_NEAR  = 3'd5;
  localparam logic [2:0] REG_DIST_FAR   = 3'd6;
  localparam logic [2:0] REG_SPEED_LIM  = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_QDIV,
    ST_LMUL,
    ST_LSCALE,
    ST_RMUL,
    ST_RSCALE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

[src/line_follow_speed_controller_unit.sv]
// Two-wheel line-following speed controller. Each item returns one result with the wheel
// drives, the motion state and the base speed. A distance item (mode 0), and a light item
// while holding or in urgent stop, goes from decode straight to the result. A light item
// while accelerating or decelerating also passes a multiply step and a scale step for the
// left wheel and then for the right wheel, and first waits on one bit-serial divider when
// the light is off track, the light span is at least 2 and the steering correction must
// be worked out. Each wheel drive is divided by 100 through a reciprocal multiplication.
// A new item is taken once the previous one has been handed to the output register; a
// result waits there until it is taken.
`default_nettype none

module line_follow_speed_controller_unit #(
  parameter int RAMP_STEP          = 1,
  parameter int MIN_FORWARD_SPEED  = 20,
  parameter int MIN_BACKWARD_SPEED = -20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  logic              mode,
  input  logic [9:0]        light,
  input  logic [7:0]        distance,
  output logic              result_valid,
  input  logic              result_stall,
  output logic signed [7:0] left_drive,
  output logic signed [7:0] right_drive,
  output logic [1:0]        motion_state,
  output logic signed [7:0] speed_now
);
  import lfsc_pkg::*;

  localparam logic signed [8:0] STEP9 = 9'(RAMP_STEP);
  localparam logic signed [8:0] MINF9 = 9'(MIN_FORWARD_SPEED);
  localparam logic signed [8:0] MINB9 = 9'(MIN_BACKWARD_SPEED);
  // Scaling by 2^24/100, rounded up, is exact for every product up to 100000.
  localparam logic [17:0]       RECIP100 = 18'd167773;

  function automatic logic signed [10:0] sat_factor(input logic signed [18:0] v);
    if (v > 19'sd1000) begin
      return 11'sd1000;
    end else if (v < -19'sd1000) begin
      return -11'sd1000;
    end else begin
      return v[10:0];
    end
  endfunction

  logic [9:0] cfg_light_low, cfg_light_high, cfg_light_min, cfg_light_max;
  logic [7:0] cfg_dist_urg, cfg_dist_near, cfg_dist_far;
  logic [6:0] cfg_speed_lim;

  state_t state, state_next;

  logic        s_mode;
  logic [9:0]  s_light;
  logic [7:0]  s_dist;

  logic [1:0]        held_state;
  logic signed [7:0] held_speed, held_left, held_right;
  logic [1:0]        res_state;
  logic signed [7:0] res_speed, res_left, res_right;
  logic signed [7:0] res_speed_next, res_left_next, res_right_next;
  logic signed [10:0] fl, fr;
  logic              negd;
  logic [DIV_W-1:0]  prod;
  logic              prod_neg;

  div_req_t          div_req;
  logic              div_done;
  logic [DIV_W-1:0]  quot;

  logic              cfg_wr;
  logic              accept;
  logic              commit;

  logic [6:0]        lim7;
  logic signed [8:0] lim9, speed9, up, up_c, up_f, dn, dn_c, dn_f;
  logic [1:0]        dist_state;
  logic signed [10:0] span, d, d_neg;
  logic [10:0]       mid_sum;
  logic [9:0]        mid, d_mag;
  logic [DVS_W-1:0]  half;
  logic              steer;
  logic [DIV_W-1:0]  q_dividend;
  logic signed [18:0] qs, fl_w, fr_w;
  logic signed [10:0] f_sel, f_neg;
  logic [9:0]        f_mag;
  logic signed [7:0] spd_neg;
  logic [6:0]        spd_mag;
  logic [DIV_W-1:0]  prod_w;
  logic [34:0]       scaled;
  logic [10:0]       drv_quot;
  logic [6:0]        drv_mag;
  logic signed [7:0] drv;

  lfsc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (quot)
  );

  assign pready       = 1'b1;
  assign cfg_wr       = psel && penable && pwrite && pready;
  assign sample_stall = (state != ST_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign commit       = (state == ST_DONE) && (!result_valid || !result_stall);

  assign left_drive   = held_left;
  assign right_drive  = held_right;
  assign motion_state = held_state;
  assign speed_now    = held_speed;

  always_comb begin
    unique case (paddr[4:2])
      REG_LIGHT_LOW:  prdata = {22'd0, cfg_light_low};
      REG_LIGHT_HIGH: prdata = {22'd0, cfg_light_high};
      REG_LIGHT_MIN:  prdata = {22'd0, cfg_light_min};
      REG_LIGHT_MAX:  prdata = {22'd0, cfg_light_max};
      REG_DIST_URG:   prdata = {24'd0, cfg_dist_urg};
      REG_DIST_NEAR:  prdata = {24'd0, cfg_dist_near};
      REG_DIST_FAR:   prdata = {24'd0, cfg_dist_far};
      REG_SPEED_LIM:  prdata = {25'd0, cfg_speed_lim};
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    lim7   = (cfg_speed_lim > 7'd100) ? 7'd100 : cfg_speed_lim;
    lim9   = signed'({2'b00, lim7});
    speed9 = {held_speed[7], held_speed};
    up     = speed9 + STEP9;
    up_c   = (up >= lim9) ? lim9 : up;
    up_f   = (up_c < MINF9 && up_c >= MINB9) ? MINF9 : up_c;
    dn     = speed9 - STEP9;
    dn_c   = (dn <= -lim9) ? -lim9 : dn;
    dn_f   = (dn_c <= MINF9 && dn_c > MINB9) ? MINB9 : dn_c;

    res_speed_next = held_speed;
    res_left_next  = held_left;
    res_right_next = held_right;
    if (s_mode) begin
      unique case (held_state)
        MS_ACCEL:  res_speed_next = up_f[7:0];
        MS_DECEL:  res_speed_next = dn_f[7:0];
        MS_URGENT: begin
          res_speed_next = -8'sd30;
          res_left_next  = -8'sd30;
          res_right_next = -8'sd30;
        end
        default: ;
      endcase
    end

    if (s_dist < cfg_dist_urg) begin
      dist_state = MS_URGENT;
    end else if (s_dist < cfg_dist_near) begin
      dist_state = MS_DECEL;
    end else if (s_dist > cfg_dist_far) begin
      dist_state = MS_ACCEL;
    end else begin
      dist_state = MS_HOLD;
    end

    span       = signed'({1'b0, cfg_light_max}) - signed'({1'b0, cfg_light_min});
    mid_sum    = {1'b0, cfg_light_min} + {1'b0, cfg_light_max};
    mid        = mid_sum[10:1];
    half       = span[9:1];
    d          = signed'({1'b0, s_light}) - signed'({1'b0, mid});
    d_neg      = -d;
    d_mag      = d[10] ? d_neg[9:0] : d[9:0];
    q_dividend = 17'(d_mag) * 17'd100;
    steer      = (span >= 11'sd2) && (s_light < cfg_light_low || s_light > cfg_light_high);

    qs   = negd ? -signed'({2'b00, quot}) : signed'({2'b00, quot});
    fl_w = 19'sd100 - qs;
    fr_w = 19'sd100 + qs;

    f_sel   = (state == ST_LMUL) ? fl : fr;
    f_neg   = -f_sel;
    f_mag   = f_sel[10] ? f_neg[9:0] : f_sel[9:0];
    spd_neg = -res_speed;
    spd_mag = res_speed[7] ? spd_neg[6:0] : res_speed[6:0];
    prod_w  = 17'(spd_mag) * 17'(f_mag);

    scaled   = 35'(prod) * 35'(RECIP100);
    drv_quot = scaled[34:24];
    drv_mag  = (drv_quot > 11'd100) ? 7'd100 : drv_quot[6:0];
    drv      = prod_neg ? -signed'({1'b0, drv_mag}) : signed'({1'b0, drv_mag});
  end

  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = q_dividend;
    div_req.divisor  = half;
    unique case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!s_mode || held_state == MS_HOLD || held_state == MS_URGENT) begin
          state_next = ST_DONE;
        end else if (steer) begin
          div_req.start = 1'b1;
          state_next    = ST_QDIV;
        end else begin
          state_next = ST_LMUL;
        end
      end
      ST_QDIV: begin
        if (div_done) begin
          state_next = ST_LMUL;
        end
      end
      ST_LMUL:   state_next = ST_LSCALE;
      ST_LSCALE: state_next = ST_RMUL;
      ST_RMUL:   state_next = ST_RSCALE;
      ST_RSCALE: state_next = ST_DONE;
      ST_DONE: begin
        if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      result_valid   <= 1'b0;
      held_state     <= MS_HOLD;
      held_speed     <= '0;
      held_left      <= '0;
      held_right     <= '0;
      cfg_light_low  <= 10'd400;
      cfg_light_high <= 10'd500;
      cfg_light_min  <= 10'd300;
      cfg_light_max  <= 10'd600;
      cfg_dist_urg   <= 8'd15;
      cfg_dist_near  <= 8'd30;
      cfg_dist_far   <= 8'd50;
      cfg_speed_lim  <= 7'd80;
    end else begin
      state <= state_next;
      if (commit) begin
        result_valid <= 1'b1;
        held_state   <= res_state;
        held_speed   <= res_speed;
        held_left    <= res_left;
        held_right   <= res_right;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (paddr[4:2])
          REG_LIGHT_LOW:  cfg_light_low  <= pwdata[9:0];
          REG_LIGHT_HIGH: cfg_light_high <= pwdata[9:0];
          REG_LIGHT_MIN:  cfg_light_min  <= pwdata[9:0];
          REG_LIGHT_MAX:  cfg_light_max  <= pwdata[9:0];
          REG_DIST_URG:   cfg_dist_urg   <= pwdata[7:0];
          REG_DIST_NEAR:  cfg_dist_near  <= pwdata[7:0];
          REG_DIST_FAR:   cfg_dist_far   <= pwdata[7:0];
          REG_SPEED_LIM:  cfg_speed_lim  <= pwdata[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_mode  <= mode;
      s_light <= light;
      s_dist  <= distance;
    end
    if (state == ST_DECODE) begin
      res_state <= s_mode ? held_state : dist_state;
      res_speed <= res_speed_next;
      res_left  <= res_left_next;
      res_right <= res_right_next;
      fl        <= 11'sd100;
      fr        <= 11'sd100;
      negd      <= d[10];
    end
    if (state == ST_QDIV && div_done) begin
      fl <= sat_factor(fl_w);
      fr <= sat_factor(fr_w);
    end
    if (state == ST_LMUL || state == ST_RMUL) begin
      prod     <= prod_w;
      prod_neg <= res_speed[7] ^ f_sel[10];
    end
    if (state == ST_LSCALE) begin
      res_left <= drv;
    end
    if (state == ST_RSCALE) begin
      res_right <= drv;
    end
  end

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_QDIV))
    else $error("divider finished outside a waiting state");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_DONE)
    else $error("result raised without a finished item");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    (left_drive >= -8'sd100 && left_drive <= 8'sd100 &&
     right_drive >= -8'sd100 && right_drive <= 8'sd100))
    else $error("wheel drive out of range");

  a_held_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_DONE) |=> $stable(speed_now) && $stable(motion_state))
    else $error("held state changed without a commit");

endmodule

`default_nettype wire

[src/lfsc_div.sv]
`default_nettype none

module lfsc_div (
  input  logic                    clk,
  input  logic                    rst,
  input  lfsc_pkg::div_req_t      req,
  output logic                    done,
  output logic [lfsc_pkg::DIV_W-1:0] quot
);
  import lfsc_pkg::*;

  logic [4:0]       count;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DIV_W-1:0] quo;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  always_comb begin
    trial = {rem, quo[DIV_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= !req.start && (count == 5'd1);
      if (req.start) begin
        count <= DIV_STEPS;
      end else if (count != 5'd0) begin
        count <= count - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvs <= req.divisor;
      quo <= req.dividend;
    end else if (count != 5'd0) begin
      rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign quot = quo;

endmodule

`default_nettype wire

[verif/tb_line_follow_speed_controller_unit.sv]
module tb_line_follow_speed_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lfsc_pkg::*;

  localparam int RAMP_STEP          = 1;
  localparam int MIN_FORWARD_SPEED  = 20;
  localparam int MIN_BACKWARD_SPEED = -20;
  localparam int HOLD_OFF_CYCLES    = 600;
  localparam int IDLE_LIMIT         = 4000;
  localparam int SETTLE_CYCLES      = 70;

  typedef struct {
    logic signed [7:0] left;
    logic signed [7:0] right;
    logic [1:0]        mstate;
    logic signed [7:0] speed;
  } drive_result_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [4:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              sample_valid;
  logic              sample_stall;
  logic              mode;
  logic [9:0]        light;
  logic [7:0]        distance;
  logic              result_valid;
  logic              result_stall;
  logic signed [7:0] left_drive;
  logic signed [7:0] right_drive;
  logic [1:0]        motion_state;
  logic signed [7:0] speed_now;

  drive_result_t pending_results[$];
  int            cfg[8];
  logic [1:0]    cur_state;
  int            cur_speed;
  int            cur_left;
  int            cur_right;
  int            mismatches;
  int            quiet_cycles;
  bit            idle_on;
  bit            hold_off_req;

  line_follow_speed_controller_unit #(
    .RAMP_STEP(RAMP_STEP),
    .MIN_FORWARD_SPEED(MIN_FORWARD_SPEED),
    .MIN_BACKWARD_SPEED(MIN_BACKWARD_SPEED)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .mode(mode),
    .light(light),
    .distance(distance),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .left_drive(left_drive),
    .right_drive(right_drive),
    .motion_state(motion_state),
    .speed_now(speed_now)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int clip(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic int steer_factor(int lt, int side);
    int lo, hi, mid, half, q;
    lo = cfg[REG_LIGHT_MIN];
    hi = cfg[REG_LIGHT_MAX];
    if (hi - lo < 2) return 100;
    mid = (lo + hi) / 2;
    half = (hi - lo) / 2;
    q = (side * (100 * (lt - mid))) / half;
    return clip(100 - q, 1000);
  endfunction

  function automatic drive_result_t advance_controller(logic m, logic [9:0] lt_in,
                                                      logic [7:0] sonar_in);
    int lt, sonar, lim, s, fl, fr;
    drive_result_t r;
    lt = int'(lt_in);
    sonar = int'(sonar_in);
    if (!m) begin
      if (sonar < cfg[REG_DIST_URG]) cur_state = MS_URGENT;
      else if (sonar < cfg[REG_DIST_NEAR]) cur_state = MS_DECEL;
      else if (sonar > cfg[REG_DIST_FAR]) cur_state = MS_ACCEL;
      else cur_state = MS_HOLD;
    end else begin
      fl = 100;
      fr = 100;
      lim = (cfg[REG_SPEED_LIM] > 100) ? 100 : cfg[REG_SPEED_LIM];
      s = cur_speed;
      if (lt < cfg[REG_LIGHT_LOW] || lt > cfg[REG_LIGHT_HIGH]) begin
        fl = steer_factor(lt, 1);
        fr = steer_factor(lt, -1);
      end
      case (cur_state)
        MS_ACCEL: begin
          s = s + RAMP_STEP;
          if (s >= lim) s = lim;
          if (s < MIN_FORWARD_SPEED && s >= MIN_BACKWARD_SPEED) s = MIN_FORWARD_SPEED;
          cur_speed = s;
          cur_left = clip((s * fl) / 100, 100);
          cur_right = clip((s * fr) / 100, 100);
        end
        MS_DECEL: begin
          s = s - RAMP_STEP;
          if (s <= -lim) s = -lim;
          if (s <= MIN_FORWARD_SPEED && s > MIN_BACKWARD_SPEED) s = MIN_BACKWARD_SPEED;
          cur_speed = s;
          cur_left = clip((s * fl) / 100, 100);
          cur_right = clip((s * fr) / 100, 100);
        end
        MS_URGENT: begin
          cur_speed = -30;
          cur_left = -30;
          cur_right = -30;
        end
        default: begin
        end
      endcase
    end
    r.left = 8'(cur_left);
    r.right = 8'(cur_right);
    r.mstate = cur_state;
    r.speed = 8'(cur_speed);
    return r;
  endfunction

  function automatic int near_value(int centre, int maxv);
    int v;
    v = centre + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > maxv) v = maxv;
    return v;
  endfunction

  function automatic logic [9:0] pick_light();
    int centre;
    logic [9:0] v;
    case ($urandom_range(0, 9))
      0: v = 10'd0;
      1: v = 10'd1023;
      2, 3, 4, 5: v = 10'($urandom_range(0, 1023));
      default: begin
        case ($urandom_range(0, 4))
          0: centre = cfg[REG_LIGHT_LOW];
          1: centre = cfg[REG_LIGHT_HIGH];
          2: centre = cfg[REG_LIGHT_MIN];
          3: centre = cfg[REG_LIGHT_MAX];
          default: centre = (cfg[REG_LIGHT_MIN] + cfg[REG_LIGHT_MAX]) / 2;
        endcase
        v = 10'(near_value(centre, 1023));
      end
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pick_distance();
    logic [7:0] v;
    case ($urandom_range(0, 9))
      0: v = 8'd0;
      1: v = 8'd255;
      2, 3, 4, 5: v = 8'($urandom_range(0, 255));
      6: v = 8'(near_value(cfg[REG_DIST_URG], 255));
      7: v = 8'(near_value(cfg[REG_DIST_NEAR], 255));
      default: v = 8'(near_value(cfg[REG_DIST_FAR], 255));
    endcase
    return v;
  endfunction

  task automatic offer_sample(input logic m, input logic [9:0] lt, input logic [7:0] sonar);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    mode <= m;
    light <= lt;
    distance <= sonar;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    pending_results.push_back(advance_controller(m, lt, sonar));
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int val);
    int mask;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SPEED_LIM: mask = 127;
      REG_DIST_URG, REG_DIST_NEAR, REG_DIST_FAR: mask = 255;
      default: mask = 1023;
    endcase
    cfg[idx] = val & mask;
    @(posedge clk);
  endtask

  task automatic set_config(input int lt_low, lt_high, lt_min, lt_max,
                            input int d_urg, d_near, d_far, lim);
    wait_drained();
    write_reg(REG_LIGHT_LOW, lt_low);
    write_reg(REG_LIGHT_HIGH, lt_high);
    write_reg(REG_LIGHT_MIN, lt_min);
    write_reg(REG_LIGHT_MAX, lt_max);
    write_reg(REG_DIST_URG, d_urg);
    write_reg(REG_DIST_NEAR, d_near);
    write_reg(REG_DIST_FAR, d_far);
    write_reg(REG_SPEED_LIM, lim);
  endtask

  task automatic set_random_config();
    set_config($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
               $urandom_range(0, 1023), $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 127));
  endtask

  // A distance item picks the motion state, then a run of light ticks ramps in it.
  task automatic run_random_items(input int n_items);
    int sent, run_len;
    sent = 0;
    while (sent < n_items) begin
      offer_sample(1'b0, pick_light(), pick_distance());
      sent++;
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 110) : $urandom_range(0, 8);
      repeat (run_len) begin
        offer_sample(1'b1, pick_light(), 8'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  task automatic test_distance_states();
    offer_sample(1'b0, 10'd0, 8'd0);
    offer_sample(1'b0, 10'd1023, 8'd14);
    offer_sample(1'b0, 10'd0, 8'd15);
    offer_sample(1'b0, 10'd1023, 8'd29);
    offer_sample(1'b0, 10'd0, 8'd30);
    offer_sample(1'b0, 10'd1023, 8'd50);
    offer_sample(1'b0, 10'd0, 8'd51);
    offer_sample(1'b0, 10'd1023, 8'd255);
  endtask

  task automatic test_ramp_and_steering();
    offer_sample(1'b0, 10'd450, 8'd255);
    offer_sample(1'b1, 10'd450, 8'd0);
    offer_sample(1'b1, 10'd0, 8'd255);
    offer_sample(1'b1, 10'd1023, 8'd0);
    offer_sample(1'b1, 10'd399, 8'd255);
    offer_sample(1'b1, 10'd400, 8'd0);
    offer_sample(1'b1, 10'd500, 8'd255);
    offer_sample(1'b1, 10'd501, 8'd0);
    offer_sample(1'b0, 10'd0, 8'd20);
    offer_sample(1'b1, 10'd0, 8'd0);
    offer_sample(1'b1, 10'd1023, 8'd0);
    offer_sample(1'b1, 10'd450, 8'd0);
    offer_sample(1'b0, 10'd0, 8'd40);
    offer_sample(1'b1, 10'd1023, 8'd0);
    offer_sample(1'b0, 10'd0, 8'd0);
    offer_sample(1'b1, 10'd300, 8'd0);
    offer_sample(1'b1, 10'd600, 8'd0);
  endtask

  task automatic test_config_sweep();
    set_config(0, 1023, 0, 1023, 0, 0, 0, 100);
    run_random_items(120);
    set_config(1023, 0, 0, 1023, 10, 128, 200, 127);
    run_random_items(120);
    set_config(1023, 0, 500, 501, 20, 60, 100, 0);
    run_random_items(120);
    set_config(1023, 0, 500, 502, 20, 60, 100, 100);
    run_random_items(120);
    set_config(300, 700, 700, 200, 20, 60, 100, 5);
    run_random_items(120);
    set_config(400, 500, 0, 3, 5, 30, 90, 1);
    run_random_items(120);
    repeat (4) begin
      set_random_config();
      run_random_items(120);
    end
  endtask

  task automatic test_backpressure();
    set_config(450, 460, 100, 900, 15, 30, 50, 100);
    offer_sample(1'b0, 10'd0, 8'd255);
    hold_off_req = 1'b1;
    repeat (30) offer_sample(1'b1, pick_light(), 8'($urandom_range(0, 255)));
  endtask

  task automatic test_quiet_finish();
    idle_on = 1'b0;
    set_random_config();
    run_random_items(300);
  endtask

  initial begin : receiver
    int n;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        result_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 14);
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
        result_stall <= 1'b0;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic signed [7:0] want,
                             input logic signed [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    drive_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d", $time,
                 left_drive, right_drive, motion_state, speed_now);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("left_drive", want.left, left_drive);
        check_field("right_drive", want.right, right_drive);
        check_field("motion_state", 8'(want.mstate), 8'(motion_state));
        check_field("speed_now", want.speed, speed_now);
      end
    end
  end

  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("** line_follow_speed_controller_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    sample_valid <= 1'b0;
    mode <= 1'b0;
    light <= '0;
    distance <= '0;
    mismatches = 0;
    idle_on = 1'b1;
    hold_off_req = 1'b0;
    cfg[REG_LIGHT_LOW] = 400;
    cfg[REG_LIGHT_HIGH] = 500;
    cfg[REG_LIGHT_MIN] = 300;
    cfg[REG_LIGHT_MAX] = 600;
    cfg[REG_DIST_URG] = 15;
    cfg[REG_DIST_NEAR] = 30;
    cfg[REG_DIST_FAR] = 50;
    cfg[REG_SPEED_LIM] = 80;
    cur_state = MS_HOLD;
    cur_speed = 0;
    cur_left = 0;
    cur_right = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_distance_states();
    test_ramp_and_steering();
    test_config_sweep();
    test_backpressure();
    test_quiet_finish();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** line_follow_speed_controller_unit: PASSED **");
    end else begin
      $display("** line_follow_speed_controller_unit: FAILED **");
    end
    $finish;
  end

endmodule
